// ----- design/bpc_pkg.sv -----
// ---------------------------------------------------------------------------
// bpc_pkg
// Shared widths, constants and types of the pressure/temperature compensator.
// ---------------------------------------------------------------------------
package bpc_pkg;

  localparam int RAW_W    = 20;
  localparam int TEMP_W   = 16;
  localparam int PRES_W   = 32;
  localparam int CAL_W    = 16;
  localparam int TCAL_W   = 48;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 5;
  localparam int ADDR_LSB = 3;

  // config register map (8-byte spacing)
  typedef enum logic [1:0] {
    REG_TEMP_CAL = 2'd0,
    REG_PRESS_A  = 2'd1,
    REG_PRESS_B  = 2'd2,
    REG_PRESS_P9 = 2'd3
  } reg_idx_t;

  localparam logic signed [25:0] FINE_OFS    = 26'sd128000;
  localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
  localparam logic [11:0]        PRESS_SCALE = 12'd3125;
  localparam logic [63:0]        X_BIAS      = 64'h0000_8000_0000_0000;
  localparam logic signed [27:0] CENTI_MUL   = 28'sd5;
  localparam logic signed [27:0] CENTI_RND   = 28'sd128;
  localparam logic signed [19:0] TEMP_MAX    = 20'sd32767;
  localparam logic signed [19:0] TEMP_MIN    = -20'sd32768;

  // pipeline depth
  localparam int N_FRONT    = 9;
  localparam int N_BACK     = 5;
  localparam int DIV_W      = 64;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = DIV_W / DIV_BITS;
  localparam int DVSR_W     = 31;
  localparam int REM_W      = DVSR_W + 1;

  typedef struct packed {
    logic signed [TEMP_W-1:0] centi;
    logic                     pvalid;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIV_W-1:0]  num;   // dividend shifts out at top, quotient enters at bottom
    logic [DVSR_W-1:0] dvsr;
    logic              neg;
    side_t             side;
  } div_stg_t;

endpackage

// ----- design/bpc_if.sv -----
// ---------------------------------------------------------------------------
// bpc_in_if / bpc_out_if
// Valid/ready channels for raw readings and compensated results.
// ---------------------------------------------------------------------------
interface bpc_in_if;
  import bpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temperature;
  logic [RAW_W-1:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [PRES_W-1:0]        pressure_q24_8;
  logic                     pressure_valid;

  modport source (output valid, temperature_centi, pressure_q24_8, pressure_valid,
                  input ready);
  modport sink   (input valid, temperature_centi, pressure_q24_8, pressure_valid,
                  output ready);
endinterface

// ----- design/bpc_div.sv -----
// ---------------------------------------------------------------------------
// bpc_div
// Pipelined restoring divider, unsigned 64 / 31 bits, DIV_BITS per stage.
// ---------------------------------------------------------------------------
module bpc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  bpc_pkg::div_stg_t  in_data,
  output logic               out_vld,
  output bpc_pkg::div_stg_t  out_data
);
  import bpc_pkg::*;

  div_stg_t               stg_r   [DIV_STAGES];
  div_stg_t               stg_nxt [DIV_STAGES];
  div_stg_t               cur     [DIV_STAGES];
  logic [DIV_STAGES-1:0]  vld_r;

  function automatic div_stg_t div_step(input div_stg_t s);
    div_stg_t         o;
    logic [REM_W-1:0] r2;
    o  = s;
    r2 = {s.rem[REM_W-2:0], s.num[DIV_W-1]};
    if (r2 >= {1'b0, s.dvsr}) begin
      o.rem = r2 - {1'b0, s.dvsr};
      o.num = {s.num[DIV_W-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.num = {s.num[DIV_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    cur[0] = in_data;
    for (int i = 1; i < DIV_STAGES; i++) begin
      cur[i] = stg_r[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      stg_nxt[i] = cur[i];
      for (int k = 0; k < DIV_BITS; k++) begin
        stg_nxt[i] = div_step(stg_nxt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_data = stg_r[DIV_STAGES-1];

endmodule

// ----- design/barometric_pressure_temp_compensation_unit.sv -----
// From input transfer to out valid: 9 front stages, 32 divider stages at
//   2 quotient bits each, 5 back stages, result reg.
// Throughput: one transfer per cycle unless stalled; fully pipelined path.
// A result reg plus one skid entry decouple the sides; input stalls only
//   when the skid entry holds a result.
// Reset (rst_n, sync, active low): pipeline empty, calibration regs zero.
// ---------------------------------------------------------------------------
// barometric_pressure_temp_compensation_unit
// Integer temperature and pressure compensation of raw barometer readings.
// ---------------------------------------------------------------------------
module barometric_pressure_temp_compensation_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  bpc_in_if.sink                     in_ch,
  bpc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::DATA_W-1:0] pwdata,
  output logic [bpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bpc_pkg::*;

  typedef struct packed {
    logic signed [TEMP_W-1:0] centi;
    logic [PRES_W-1:0]        pres;
    logic                     pvalid;
  } res_t;

  // -------------------------------------------------------------------------
  // Calibration registers (APB; user writes only while idle, not enforced)
  // -------------------------------------------------------------------------
  logic [TCAL_W-1:0] temp_cal_r;
  logic [DATA_W-1:0] press_a_r;
  logic [DATA_W-1:0] press_b_r;
  logic [CAL_W-1:0]  p9_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      p9_r       <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TEMP_CAL: temp_cal_r <= pwdata[TCAL_W-1:0];
        REG_PRESS_A:  press_a_r  <= pwdata;
        REG_PRESS_B:  press_b_r  <= pwdata;
        REG_PRESS_P9: p9_r       <= pwdata[CAL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEMP_CAL: prdata = {{(DATA_W-TCAL_W){1'b0}}, temp_cal_r};
      REG_PRESS_A:  prdata = press_a_r;
      REG_PRESS_B:  prdata = press_b_r;
      REG_PRESS_P9: prdata = {{(DATA_W-CAL_W){1'b0}}, p9_r};
    endcase
  end

  // coefficient slices
  logic [CAL_W-1:0]        t1, p1;
  logic signed [CAL_W-1:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_cal_r[15:0];
  assign t2 = temp_cal_r[31:16];
  assign t3 = temp_cal_r[47:32];
  assign p1 = press_a_r[15:0];
  assign p2 = press_a_r[31:16];
  assign p3 = press_a_r[47:32];
  assign p4 = press_a_r[63:48];
  assign p5 = press_b_r[15:0];
  assign p6 = press_b_r[31:16];
  assign p7 = press_b_r[47:32];
  assign p8 = press_b_r[63:48];
  assign p9 = p9_r;

  // -------------------------------------------------------------------------
  // Pipeline control: every stage moves together; only a full skid entry
  // stops it, so ready is a register output.
  // -------------------------------------------------------------------------
  logic               en;
  logic [N_FRONT-1:0] vf_r;
  logic [N_BACK-1:0]  vb_r;
  logic               div_out_vld;
  div_stg_t           div_out;
  logic               out_v_r, sk_v_r;
  res_t               out_d_r, sk_d_r, res;

  assign en          = !sk_v_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
      vb_r <= '0;
    end else if (en) begin
      vf_r <= {vf_r[N_FRONT-2:0], in_ch.valid};
      vb_r <= {vb_r[N_BACK-2:0], div_out_vld};
    end
  end

  // -------------------------------------------------------------------------
  // S1: temperature differences and first products
  // -------------------------------------------------------------------------
  logic signed [17:0] s1_ta;
  logic signed [16:0] s1_d;
  logic signed [33:0] s1_dd_full;
  logic signed [33:0] s1_pa_nxt, s1_pa_r;
  logic [32:0]        s1_dd_nxt, s1_dd_r;
  logic [RAW_W-1:0]   s1_adcp_r;

  always_comb begin
    s1_ta      = $signed({1'b0, in_ch.raw_temperature[RAW_W-1:3]})
               - $signed({1'b0, t1, 1'b0});
    s1_d       = $signed({1'b0, in_ch.raw_temperature[RAW_W-1:4]})
               - $signed({1'b0, t1});
    s1_pa_nxt  = s1_ta * t2;
    s1_dd_full = s1_d * s1_d;
    s1_dd_nxt  = s1_dd_full[32:0];   // square, never negative
  end

  // S2: var1 term done, var2 term multiplied by T3
  logic signed [22:0] s2_a_nxt, s2_a_r;
  logic signed [37:0] s2_bt_nxt, s2_bt_r;
  logic [RAW_W-1:0]   s2_adcp_r;

  always_comb begin
    s2_a_nxt  = s1_pa_r[33:11];
    s2_bt_nxt = $signed({1'b0, s1_dd_r[32:12]}) * t3;
  end

  // S3: fine temperature
  logic signed [24:0] s3_fine_nxt, s3_fine_r;
  logic [RAW_W-1:0]   s3_adcp_r;

  always_comb begin
    s3_fine_nxt = $signed({{2{s2_a_r[22]}}, s2_a_r})
                + $signed({s2_bt_r[37], s2_bt_r[37:14]});
  end

  // S4: centi-degrees with saturation; pressure var1 and its first products
  logic signed [27:0]       s4_c;
  logic signed [19:0]       s4_cs;
  logic signed [25:0]       s4_v1;
  logic signed [TEMP_W-1:0] s4_centi_nxt, s4_centi_r;
  logic signed [51:0]       s4_vv_nxt, s4_vv_r;
  logic signed [41:0]       s4_v1p5_nxt, s4_v1p5_r, s4_v1p2_nxt, s4_v1p2_r;
  logic [RAW_W-1:0]         s4_adcp_r;

  always_comb begin
    s4_c  = s3_fine_r * CENTI_MUL + CENTI_RND;
    s4_cs = s4_c[27:8];
    if (s4_cs > TEMP_MAX) begin
      s4_centi_nxt = TEMP_MAX[TEMP_W-1:0];
    end else if (s4_cs < TEMP_MIN) begin
      s4_centi_nxt = TEMP_MIN[TEMP_W-1:0];
    end else begin
      s4_centi_nxt = s4_cs[TEMP_W-1:0];
    end
    s4_v1       = $signed({s3_fine_r[24], s3_fine_r}) - FINE_OFS;
    s4_vv_nxt   = s4_v1 * s4_v1;
    s4_v1p5_nxt = s4_v1 * p5;
    s4_v1p2_nxt = s4_v1 * p2;
  end

  // S5: square terms times P6 and P3 (mod 2^64)
  logic signed [67:0]       s5_t6, s5_t3;
  logic [63:0]              s5_vvp6_nxt, s5_vvp6_r, s5_vvp3_nxt, s5_vvp3_r;
  logic signed [41:0]       s5_v1p5_r, s5_v1p2_r;
  logic signed [TEMP_W-1:0] s5_centi_r;
  logic [RAW_W-1:0]         s5_adcp_r;

  always_comb begin
    s5_t6       = s4_vv_r * p6;
    s5_t3       = s4_vv_r * p3;
    s5_vvp6_nxt = s5_t6[63:0];
    s5_vvp3_nxt = s5_t3[63:0];
  end

  // S6: var2 sum; var1 sum with 2^47 bias
  logic [63:0]              s6_v2_nxt, s6_v2_r, s6_x_nxt, s6_x_r;
  logic signed [TEMP_W-1:0] s6_centi_r;
  logic [RAW_W-1:0]         s6_adcp_r;

  always_comb begin
    s6_v2_nxt = s5_vvp6_r
              + {{5{s5_v1p5_r[41]}}, s5_v1p5_r, 17'b0}
              + {{13{p4[15]}}, p4, 35'b0};
    s6_x_nxt  = {{8{s5_vvp3_r[63]}}, s5_vvp3_r[63:8]}
              + {{10{s5_v1p2_r[41]}}, s5_v1p2_r, 12'b0}
              + X_BIAS;
  end

  // S7: times P1; numerator base
  logic [79:0]              s7_t;
  logic [20:0]              s7_pm;
  logic [63:0]              s7_xp1_nxt, s7_xp1_r, s7_d0_nxt, s7_d0_r;
  logic signed [TEMP_W-1:0] s7_centi_r;

  always_comb begin
    s7_t       = s6_x_r * p1;
    s7_xp1_nxt = s7_t[63:0];
    s7_pm      = PRESS_BASE - {1'b0, s6_adcp_r};
    s7_d0_nxt  = {12'b0, s7_pm, 31'b0} - s6_v2_r;
  end

  // S8: divisor (var1 >> 33) and numerator times 3125
  logic [75:0]              s8_t;
  logic [63:0]              s8_num_nxt, s8_num_r;
  logic [DVSR_W-1:0]        s8_den_nxt, s8_den_r;
  logic signed [TEMP_W-1:0] s8_centi_r;

  always_comb begin
    s8_den_nxt = s7_xp1_r[63:33];
    s8_t       = s7_d0_r * PRESS_SCALE;
    s8_num_nxt = s8_t[63:0];
  end

  // S9: magnitudes and sign for the divider
  div_stg_t s9_nxt, s9_r;

  always_comb begin
    s9_nxt.rem         = '0;
    s9_nxt.num         = s8_num_r[63] ? (64'd0 - s8_num_r) : s8_num_r;
    s9_nxt.dvsr        = s8_den_r[DVSR_W-1] ? (~s8_den_r + 1'b1) : s8_den_r;
    s9_nxt.neg         = s8_num_r[63] ^ s8_den_r[DVSR_W-1];
    s9_nxt.side.centi  = s8_centi_r;
    s9_nxt.side.pvalid = |s8_den_r;   // zero divisor: result forced to 0
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pa_r     <= s1_pa_nxt;
      s1_dd_r     <= s1_dd_nxt;
      s1_adcp_r   <= in_ch.raw_pressure;
      s2_a_r      <= s2_a_nxt;
      s2_bt_r     <= s2_bt_nxt;
      s2_adcp_r   <= s1_adcp_r;
      s3_fine_r   <= s3_fine_nxt;
      s3_adcp_r   <= s2_adcp_r;
      s4_centi_r  <= s4_centi_nxt;
      s4_vv_r     <= s4_vv_nxt;
      s4_v1p5_r   <= s4_v1p5_nxt;
      s4_v1p2_r   <= s4_v1p2_nxt;
      s4_adcp_r   <= s3_adcp_r;
      s5_vvp6_r   <= s5_vvp6_nxt;
      s5_vvp3_r   <= s5_vvp3_nxt;
      s5_v1p5_r   <= s4_v1p5_r;
      s5_v1p2_r   <= s4_v1p2_r;
      s5_centi_r  <= s4_centi_r;
      s5_adcp_r   <= s4_adcp_r;
      s6_v2_r     <= s6_v2_nxt;
      s6_x_r      <= s6_x_nxt;
      s6_centi_r  <= s5_centi_r;
      s6_adcp_r   <= s5_adcp_r;
      s7_xp1_r    <= s7_xp1_nxt;
      s7_d0_r     <= s7_d0_nxt;
      s7_centi_r  <= s6_centi_r;
      s8_num_r    <= s8_num_nxt;
      s8_den_r    <= s8_den_nxt;
      s8_centi_r  <= s7_centi_r;
      s9_r        <= s9_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Divider: 32 stages
  // -------------------------------------------------------------------------
  bpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vf_r[N_FRONT-1]),
    .in_data  (s9_r),
    .out_vld  (div_out_vld),
    .out_data (div_out)
  );

  // -------------------------------------------------------------------------
  // Back stages
  // -------------------------------------------------------------------------
  // B1: signed quotient
  logic [63:0] b1_p_nxt, b1_p_r;
  side_t       b1_side_r;

  assign b1_p_nxt = div_out.neg ? (64'd0 - div_out.num) : div_out.num;

  // B2: partial products of (p>>13)^2, and P8 * p
  logic [63:0]        b2_x, b2_ll_nxt, b2_ll_r, b2_lh_full, b2_p8p_nxt, b2_p8p_r, b2_p_r;
  logic signed [79:0] b2_t8;
  logic [31:0]        b2_lh_nxt, b2_lh_r;
  side_t              b2_side_r;

  always_comb begin
    b2_x       = {{13{b1_p_r[63]}}, b1_p_r[63:13]};
    b2_ll_nxt  = b2_x[31:0] * b2_x[31:0];
    b2_lh_full = b2_x[31:0] * b2_x[63:32];
    b2_lh_nxt  = b2_lh_full[31:0];
    b2_t8      = $signed(b1_p_r) * p8;
    b2_p8p_nxt = b2_t8[63:0];
  end

  // B3: square sum (mod 2^64) and var2 = (P8 * p) >> 19
  logic [63:0] b3_xx_nxt, b3_xx_r, b3_v2_nxt, b3_v2_r, b3_p_r;
  side_t       b3_side_r;

  always_comb begin
    b3_xx_nxt = b2_ll_r + {b2_lh_r[30:0], 33'b0};
    b3_v2_nxt = {{19{b2_p8p_r[63]}}, b2_p8p_r[63:19]};
  end

  // B4: P9 times square
  logic signed [79:0] b4_t;
  logic [63:0]        b4_v1_nxt, b4_v1_r, b4_v2_r, b4_p_r;
  side_t              b4_side_r;

  always_comb begin
    b4_t      = $signed(b3_xx_r) * p9;
    b4_v1_nxt = b4_t[63:0];
  end

  // B5: p + var1 + var2
  logic [63:0] b5_s_nxt, b5_s_r;
  side_t       b5_side_r;

  assign b5_s_nxt = b4_p_r + {{25{b4_v1_r[63]}}, b4_v1_r[63:25]} + b4_v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b1_p_r    <= b1_p_nxt;
      b1_side_r <= div_out.side;
      b2_ll_r   <= b2_ll_nxt;
      b2_lh_r   <= b2_lh_nxt;
      b2_p8p_r  <= b2_p8p_nxt;
      b2_p_r    <= b1_p_r;
      b2_side_r <= b1_side_r;
      b3_xx_r   <= b3_xx_nxt;
      b3_v2_r   <= b3_v2_nxt;
      b3_p_r    <= b2_p_r;
      b3_side_r <= b2_side_r;
      b4_v1_r   <= b4_v1_nxt;
      b4_v2_r   <= b3_v2_r;
      b4_p_r    <= b3_p_r;
      b4_side_r <= b3_side_r;
      b5_s_r    <= b5_s_nxt;
      b5_side_r <= b4_side_r;
    end
  end

  // final scale, P7 offset, clamp to unsigned 32 bits
  logic [63:0] fin;

  always_comb begin
    fin          = {{8{b5_s_r[63]}}, b5_s_r[63:8]} + {{44{p7[15]}}, p7, 4'b0};
    res.centi    = b5_side_r.centi;
    res.pvalid   = b5_side_r.pvalid;
    if (!b5_side_r.pvalid || fin[63]) begin
      res.pres = '0;
    end else if (|fin[63:PRES_W]) begin
      res.pres = '1;
    end else begin
      res.pres = fin[PRES_W-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Result register + skid entry
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end else begin
        out_v_r <= vb_r[N_BACK-1];
      end
    end else if (en && vb_r[N_BACK-1]) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_d_r <= sk_v_r ? sk_d_r : res;
    end else if (en) begin
      sk_d_r <= res;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.temperature_centi = out_d_r.centi;
  assign out_ch.pressure_q24_8    = out_d_r.pres;
  assign out_ch.pressure_valid    = out_d_r.pvalid;

`ifndef SYNTHESIS
  // an invalid pressure is always reported as zero
  a_inval_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.pressure_valid |-> out_ch.pressure_q24_8 == '0)
    else $error("invalid pressure not zero");

  // skid holds data only behind a waiting result
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid full with empty result reg");

  // a taken result is replaced by the skid entry
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r && out_ch.ready |=> out_v_r && !sk_v_r)
    else $error("skid entry not drained");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the barometric compensation unit: random and
// directed raw reading pairs under several calibration sets and idling mixes.
// ---------------------------------------------------------------------------
module testbench;
  import bpc_pkg::*;

  typedef struct {
    logic signed [TEMP_W-1:0] centi;
    logic [PRES_W-1:0]        pres;
    logic                     pvalid;
  } reading_t;

  // Expected readings and the compensation arithmetic that produces them.
  class reading_board;
    logic [TCAL_W-1:0] tcal;
    logic [63:0]       pcal_a, pcal_b;
    logic [CAL_W-1:0]  pcal_p9;
    reading_t          pending[$];
    int                errors, matched, invalid_seen;

    function longint sdiv(longint num, longint den);
      longint unsigned mn, md, q;
      mn = (num < 0) ? 64'd0 - num : num;
      md = (den < 0) ? 64'd0 - den : den;
      q  = mn / md;
      return ((num < 0) != (den < 0)) ? 64'd0 - q : q;
    endfunction

    function reading_t compensate(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
      reading_t r;
      longint at, ap, t1, t2, t3, a, b, d, fine, c;
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
      at = rt; ap = rp;
      t1 = tcal[15:0];
      t2 = $signed(tcal[31:16]);
      t3 = $signed(tcal[47:32]);
      // temperature: full width, floor shifts
      a = (((at >>> 3) - t1 * 2) * t2) >>> 11;
      d = (at >>> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      fine = a + b;
      c = (fine * 5 + 128) >>> 8;
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      r.centi = c[15:0];
      // pressure: 64-bit wrapping
      p1 = pcal_a[15:0];
      p2 = $signed(pcal_a[31:16]);
      p3 = $signed(pcal_a[47:32]);
      p4 = $signed(pcal_a[63:48]);
      p5 = $signed(pcal_b[15:0]);
      p6 = $signed(pcal_b[31:16]);
      p7 = $signed(pcal_b[47:32]);
      p8 = $signed(pcal_b[63:48]);
      p9 = $signed(pcal_p9);
      v1 = fine - 128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
        r.pres = '0;
        r.pvalid = 1'b0;
      end else begin
        p  = 1048576 - ap;
        p  = sdiv(((p <<< 31) - v2) * 3125, v1);
        v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
        v2 = (p8 * p) >>> 19;
        p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
        if (p < 0) r.pres = '0;
        else if (p > 64'shFFFFFFFF) r.pres = '1;
        else r.pres = p[31:0];
        r.pvalid = 1'b1;
      end
      return r;
    endfunction

    function void note_reading(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
      pending.push_back(compensate(rt, rp));
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(reading_t got);
      reading_t e;
      if (pending.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.centi !== e.centi)
        report($sformatf("temperature %0d, want %0d", got.centi, e.centi));
      else if (got.pres !== e.pres)
        report($sformatf("pressure %h, want %h", got.pres, e.pres));
      else if (got.pvalid !== e.pvalid)
        report($sformatf("pressure_valid %b, want %b", got.pvalid, e.pvalid));
      else begin
        matched++;
        if (!e.pvalid) invalid_seen++;
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  bpc_in_if  in_ch();
  bpc_out_if out_ch();

  barometric_pressure_temp_compensation_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  reading_board board = new();

  int  send_idle_pct = 0;   // chance of a gap before each item
  int  stall_pct = 0;       // chance the receiver drops ready
  bit  hold_out = 1'b0;     // long receiver hold-off in progress
  int  quiet = 0;
  int  sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: check each transfer, then pick ready for the next cycle.
  always @(posedge clk) begin
    reading_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.centi  = out_ch.temperature_centi;
      got.pres   = out_ch.pressure_q24_8;
      got.pvalid = out_ch.pressure_valid;
      board.check_result(got);
    end
    out_ch.ready <= rst_n && !hold_out && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: cycles with no transfer on either channel and no APB access.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("Watchdog expired, %0d readings outstanding", board.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // APB write: setup, then access until pready.
  task write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << ADDR_LSB;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TEMP_CAL: board.tcal    = value[TCAL_W-1:0];
      REG_PRESS_A:  board.pcal_a  = value;
      REG_PRESS_B:  board.pcal_b  = value;
      REG_PRESS_P9: board.pcal_p9 = value[CAL_W-1:0];
    endcase
  endtask

  task load_cal(logic [47:0] t, logic [63:0] a, logic [63:0] b, logic [15:0] p9);
    write_reg(REG_TEMP_CAL, {16'h0, t});
    write_reg(REG_PRESS_A, a);
    write_reg(REG_PRESS_B, b);
    write_reg(REG_PRESS_P9, {48'h0, p9});
  endtask

  // One reading pair; valid stays up across back-to-back transfers.
  task send_reading(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_temperature <= rt;
    in_ch.raw_pressure <= rp;
    do @(posedge clk); while (!in_ch.ready);
    board.note_reading(rt, rp);
    sent++;
  endtask

  task send_random(int n);
    repeat (n) begin
      if ($urandom_range(99) < 75)
        send_reading(RAW_W'($urandom_range(380000, 620000)),
                     RAW_W'($urandom_range(180000, 520000)));
      else
        send_reading(RAW_W'($urandom_range(20'hFFFFF)), RAW_W'($urandom_range(20'hFFFFF)));
    end
  endtask

  // Stop offering and let every outstanding result drain, plus pipeline depth.
  task drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Typical factory calibration set
  localparam logic [47:0] T_TYP = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] A_TYP = {16'd2855, 16'd3024, 16'hD843, 16'd36477};
  localparam logic [63:0] B_TYP = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Calibration all zero after reset: P1 = 0 forces the zero divisor case.
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(20'd519888, 20'd415148);
    drain();

    // Directed: typical set, field extremes, temperature saturation.
    load_cal(T_TYP, A_TYP, B_TYP, 16'd6000);
    send_reading(20'd519888, 20'd415148);
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading('0, '1);
    send_reading('1, '0);
    send_reading(20'hAAAAA, 20'h55555);
    send_reading(20'h55555, 20'hAAAAA);
    send_reading(20'd1048575, 20'd300000);  // hot, clamps toward upper bound
    send_reading(20'd0, 20'd300000);
    drain();
    // Extremes of every coefficient: negative pressure clamps, saturation.
    load_cal('1, '1, '1, 16'hFFFF);
    send_reading(20'd519888, 20'd415148);
    send_reading('1, '0);
    send_reading('0, '1);
    drain();
    load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
             {4{16'h7FFF}}, 16'h7FFF);
    send_reading('1, '0);
    send_reading('0, '0);
    send_reading(20'd519888, 20'd1);
    drain();
    load_cal({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
             {4{16'h8000}}, 16'h8000);
    send_reading('1, '1);
    send_reading('0, '0);
    send_reading(20'd519888, 20'd415148);
    drain();

    // Random phases with the idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_cal(T_TYP, A_TYP, B_TYP, 16'd6000);
        1: load_cal(T_TYP ^ 48'($urandom_range(16'hFF)),
                    A_TYP ^ 64'($urandom_range(16'hFF)), B_TYP, 16'($urandom));
        2: load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom));
        default: load_cal(T_TYP, {A_TYP[63:16], 16'($urandom_range(1, 65535))},
                          {$urandom, $urandom}, 16'($urandom));
      endcase
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 86 : 37) : 0;
      stall_pct     = (ph == 2 || ph == 3) ? ((ph == 2) ? 86 : 37) : 0;
      if (ph == 0) begin
        // Long receiver hold-off while the sender keeps offering.
        fork
          begin
            hold_out = 1'b1;
            repeat (300) @(posedge clk);
            hold_out = 1'b0;
          end
          send_random(120);
        join
        send_random(100);
        drain();  // sender pauses until every result is back
        send_random(130);
      end else
        send_random(340);
      drain();
    end
    stall_pct = 0;

    if (board.pending.size() != 0)
      board.report($sformatf("%0d readings never returned", board.pending.size()));
    $display("Covered %0d reading pairs over 8 calibration sets, %0d matched,",
             sent, board.matched);
    $display("%0d with zero divisor; idle and stall mixes plus a long hold-off.",
             board.invalid_seen);
    if (board.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- filelist.f -----
design/bpc_pkg.sv
design/bpc_if.sv
design/bpc_div.sv
design/barometric_pressure_temp_compensation_unit.sv
sim/testbench.sv
